// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the active cell map RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of i_clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never hold on a rising edge of i_clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/acmdc_pkg.sv
// ----------------------------------------------------------------------------
// acmdc_pkg
// Types, codes and default sizes shared by the active cell map modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acmdc_pkg;

    // Default grid and chunk sizes.
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int CHUNK_CELLS = 64;

    // Request codes.
    localparam logic [1:0] REQ_ADD          = 2'd0;
    localparam logic [1:0] REQ_ADD_NEIGHBOR = 2'd1;
    localparam logic [1:0] REQ_REMOVE       = 2'd2;
    localparam logic [1:0] REQ_NOP          = 2'd3;

    // Neighbourhood codes.
    localparam logic [1:0] NBR_SQUARE  = 2'd0;
    localparam logic [1:0] NBR_HEX_COL = 2'd1;
    localparam logic [1:0] NBR_HEX_ROW = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRID_ROWS    = 3'd0;
    localparam logic [2:0] CFG_GRID_COLUMNS = 3'd1;
    localparam logic [2:0] CFG_TOROIDAL     = 3'd2;
    localparam logic [2:0] CFG_NBR_KIND     = 3'd3;
    localparam logic [2:0] CFG_HEX_SHIFT    = 3'd4;
    localparam logic [2:0] CFG_NBR_OFFSETS  = 3'd5;

    typedef struct packed {
        logic [8:0]  grid_rows;
        logic [8:0]  grid_columns;
        logic        toroidal_mode;
        logic [1:0]  neighborhood_kind;
        logic [3:0]  hex_index_shift;
        logic [63:0] neighbor_offsets;
    } t_cfg;

    typedef struct packed {
        logic       oor;
        logic [8:0] row;
        logic [8:0] col;
    } t_target;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_DIV,
        ST_FIX,
        ST_RMW
    } t_state;

endpackage

// File: rtl/active_cell_map_with_dirty_chunks.sv
// ----------------------------------------------------------------------------
// active_cell_map_with_dirty_chunks
// Active cell set of a 2D cellular automaton grid with dirty chunk tracking.
// ----------------------------------------------------------------------------
// Each accepted word adds a cell, adds a neighbour of a cell or removes a
// cell, and yields exactly one result word. The active bits of one chunk and
// that chunk's dirty bit share one word of a single chunk RAM, so a request is
// one read-modify-write of that word. A request passes from acceptance to a
// registered result through target resolution and linear index, reciprocal
// multiply, quotient correction with the RAM read, then the read-modify-write.
// The block takes one request at a time through the chunk RAM, so the next
// word is accepted only once the last result is loaded, while that result may
// still wait in the output register. After reset a clearing pass writes every
// RAM word, one per cycle (CHUNK_COUNT words, 1024 with the default sizes),
// during which no request is taken; configuration writes are taken at any
// time and should only be made while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module active_cell_map_with_dirty_chunks #(
    parameter int MAX_ROWS    = acmdc_pkg::MAX_ROWS,
    parameter int MAX_COLS    = acmdc_pkg::MAX_COLS,
    parameter int CHUNK_CELLS = acmdc_pkg::CHUNK_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [3:0]  i_neighbor_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_target_row,
    output logic [7:0]  o_target_col,
    output logic        o_changed,
    output logic [9:0]  o_chunk_index,
    output logic        o_out_of_range
);

    localparam int CELL_COUNT  = MAX_ROWS * MAX_COLS;
    localparam int CHUNK_COUNT = (CELL_COUNT + CHUNK_CELLS - 1) / CHUNK_CELLS;
    localparam int LIN_W       = $clog2(CELL_COUNT);
    localparam int CHK_AW      = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int OFF_W       = (CHUNK_CELLS > 1) ? $clog2(CHUNK_CELLS) : 1;
    localparam int REM_W       = ((LIN_W > $clog2(CHUNK_CELLS + 1)) ? LIN_W
                                 : $clog2(CHUNK_CELLS + 1)) + 1;
    localparam int WORD_W      = CHUNK_CELLS + 1;
    localparam int PROD_W      = 2 * LIN_W + 1;
    localparam int RECIP       = (2 ** LIN_W) / CHUNK_CELLS;

    localparam logic [LIN_W:0]    RECIP_L  = (LIN_W + 1)'(RECIP);
    localparam logic [REM_W-1:0]  CHUNK_R  = REM_W'(CHUNK_CELLS);
    localparam logic [CHK_AW-1:0] CLR_LAST = CHK_AW'(CHUNK_COUNT - 1);

    acmdc_pkg::t_state  r_state;
    acmdc_pkg::t_state  n_state;
    acmdc_pkg::t_cfg    r_cfg;
    acmdc_pkg::t_target w_target;

    logic [CHK_AW-1:0] r_clr_addr;

    logic [1:0]        r_req;
    logic [7:0]        r_row;
    logic [7:0]        r_col;
    logic [3:0]        r_nidx;
    logic [7:0]        r_tr;
    logic [7:0]        r_tc;
    logic              r_oor;
    logic [LIN_W-1:0]  r_lin;
    logic [LIN_W-1:0]  w_lin;
    logic [PROD_W-1:0] r_prod;
    logic [CHK_AW-1:0] w_qest;
    logic [CHK_AW-1:0] r_chunk;
    logic [OFF_W-1:0]  r_off;

    logic [REM_W-1:0]  w_rem;
    logic              w_fix;
    logic [CHK_AW-1:0] w_q;
    logic [OFF_W-1:0]  w_off;

    logic              w_ram_we;
    logic [CHK_AW-1:0] w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;
    logic [CHK_AW-1:0] w_ram_raddr;
    logic [WORD_W-1:0] w_ram_rdata;
    logic [WORD_W-1:0] w_new_word;
    logic [CHUNK_CELLS-1:0] w_flags;

    logic w_accept;
    logic w_active;
    logic w_want;
    logic w_changed;
    logic w_out_load;

    logic       r_out_valid;
    logic [7:0] r_out_row;
    logic [7:0] r_out_col;
    logic       r_out_changed;
    logic [9:0] r_out_chunk;
    logic       r_out_oor;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows         <= 9'd256;
            r_cfg.grid_columns      <= 9'd256;
            r_cfg.toroidal_mode     <= 1'b0;
            r_cfg.neighborhood_kind <= acmdc_pkg::NBR_SQUARE;
            r_cfg.hex_index_shift   <= 4'd7;
            r_cfg.neighbor_offsets  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acmdc_pkg::CFG_GRID_ROWS:    r_cfg.grid_rows         <= i_cfg_data[8:0];
                acmdc_pkg::CFG_GRID_COLUMNS: r_cfg.grid_columns      <= i_cfg_data[8:0];
                acmdc_pkg::CFG_TOROIDAL:     r_cfg.toroidal_mode     <= i_cfg_data[0];
                acmdc_pkg::CFG_NBR_KIND:     r_cfg.neighborhood_kind <= i_cfg_data[1:0];
                acmdc_pkg::CFG_HEX_SHIFT:    r_cfg.hex_index_shift   <= i_cfg_data[3:0];
                acmdc_pkg::CFG_NBR_OFFSETS:  r_cfg.neighbor_offsets  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == acmdc_pkg::ST_RMW) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acmdc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            acmdc_pkg::ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = acmdc_pkg::ST_IDLE;
                end
            end
            acmdc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = acmdc_pkg::ST_ADDR;
                end
            end
            acmdc_pkg::ST_ADDR: n_state = acmdc_pkg::ST_DIV;
            acmdc_pkg::ST_DIV:  n_state = acmdc_pkg::ST_FIX;
            acmdc_pkg::ST_FIX:  n_state = acmdc_pkg::ST_RMW;
            acmdc_pkg::ST_RMW: begin
                if (w_out_load) begin
                    n_state = acmdc_pkg::ST_IDLE;
                end
            end
            default: n_state = acmdc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == acmdc_pkg::ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Target resolution and chunk split
    // ------------------------------------------------------------------
    acmdc_target #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .LIN_W    (LIN_W)
    ) u_target (
        .i_req_type       (r_req),
        .i_row            (r_row),
        .i_col            (r_col),
        .i_neighbor_index (r_nidx),
        .i_cfg            (r_cfg),
        .o_target         (w_target),
        .o_lin            (w_lin)
    );

    // The reciprocal estimate of the chunk number is at most one short, so a
    // single compare and subtract gives the exact quotient and remainder.
    assign w_rem = REM_W'(r_lin) - REM_W'(w_qest) * CHUNK_R;
    assign w_fix = (w_rem >= CHUNK_R);
    assign w_q   = w_qest + CHK_AW'(w_fix);
    assign w_off = OFF_W'(w_fix ? (w_rem - CHUNK_R) : w_rem);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_row  <= i_row;
            r_col  <= i_col;
            r_nidx <= i_neighbor_index;
        end
        if (r_state == acmdc_pkg::ST_ADDR) begin
            r_tr  <= w_target.row[7:0];
            r_tc  <= w_target.col[7:0];
            r_oor <= w_target.oor;
            r_lin <= w_lin;
        end
        if (r_state == acmdc_pkg::ST_DIV) begin
            r_prod <= PROD_W'(r_lin) * PROD_W'(RECIP_L);
        end
        if (r_state == acmdc_pkg::ST_FIX) begin
            r_chunk <= w_q;
            r_off   <= w_off;
        end
    end

    always_comb begin
        w_qest = r_prod[LIN_W +: CHK_AW];
    end

    // ------------------------------------------------------------------
    // Chunk RAM: active bits of one chunk plus its dirty bit on top
    // ------------------------------------------------------------------
    assign w_ram_raddr = (r_state == acmdc_pkg::ST_FIX) ? w_q : r_chunk;

    assign w_flags   = w_ram_rdata[CHUNK_CELLS-1:0];
    assign w_active  = !r_oor && (r_req != acmdc_pkg::REQ_NOP);
    assign w_want    = (r_req != acmdc_pkg::REQ_REMOVE);
    assign w_changed = w_active && (w_flags[r_off] != w_want);

    always_comb begin
        w_new_word              = w_ram_rdata;
        w_new_word[r_off]       = w_want;
        w_new_word[CHUNK_CELLS] = 1'b1;
    end

    assign w_ram_we    = (r_state == acmdc_pkg::ST_CLEAR) || (w_out_load && w_changed);
    assign w_ram_waddr = (r_state == acmdc_pkg::ST_CLEAR) ? r_clr_addr : r_chunk;
    assign w_ram_wdata = (r_state == acmdc_pkg::ST_CLEAR) ? '0 : w_new_word;

    acmdc_ram #(
        .P_WIDTH  (WORD_W),
        .P_DEPTH  (CHUNK_COUNT),
        .P_ADDR_W (CHK_AW)
    ) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_row     <= w_active ? r_tr : 8'd0;
            r_out_col     <= w_active ? r_tc : 8'd0;
            r_out_changed <= w_changed;
            r_out_chunk   <= w_changed ? 10'(r_chunk) : 10'd0;
            r_out_oor     <= r_oor && (r_req != acmdc_pkg::REQ_NOP);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target_row   = r_out_row;
    assign o_target_col   = r_out_col;
    assign o_changed      = r_out_changed;
    assign o_chunk_index  = r_out_chunk;
    assign o_out_of_range = r_out_oor;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_ram_we_state,
        w_ram_we && (r_state != acmdc_pkg::ST_RMW) && (r_state != acmdc_pkg::ST_CLEAR),
        "chunk RAM written outside clearing or read-modify-write")
    `ASSERT_CLK(a_result_from_rmw,
        $rose(r_out_valid) |-> ($past(r_state) == acmdc_pkg::ST_RMW),
        "result word appeared without a read-modify-write")
    `ASSERT_CLK(a_accept_starts,
        w_accept |=> (r_state == acmdc_pkg::ST_ADDR),
        "accepted word did not start target resolution")
    `ASSERT_CLK(a_rem_bound,
        (r_state == acmdc_pkg::ST_FIX) |-> ((w_rem < CHUNK_R) || ((w_rem - CHUNK_R) < CHUNK_R)),
        "chunk quotient estimate off by more than one")
    `ASSERT_NEVER(a_change_in_range,
        r_out_valid && o_changed && o_out_of_range,
        "out-of-range request reported a change")

endmodule

// File: rtl/acmdc_ram.sv
// ----------------------------------------------------------------------------
// acmdc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acmdc_ram #(
    parameter int P_WIDTH  = 8,
    parameter int P_DEPTH  = 16,
    parameter int P_ADDR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [P_ADDR_W-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]  i_wdata,
    input  logic [P_ADDR_W-1:0] i_raddr,
    output logic [P_WIDTH-1:0]  o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/acmdc_target.sv
// ----------------------------------------------------------------------------
// acmdc_target
// Resolves the addressed cell of a request: neighbour table lookup, hex index
// shift, toroidal wrap, bounds check and the row-major linear cell index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acmdc_target #(
    parameter int MAX_ROWS = acmdc_pkg::MAX_ROWS,
    parameter int MAX_COLS = acmdc_pkg::MAX_COLS,
    parameter int LIN_W    = 16
) (
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_col,
    input  logic [3:0]         i_neighbor_index,
    input  acmdc_pkg::t_cfg    i_cfg,
    output acmdc_pkg::t_target o_target,
    output logic [LIN_W-1:0]   o_lin
);

    localparam logic [12:0] LIM_ROWS = 13'(MAX_ROWS);
    localparam logic [12:0] LIM_COLS = 13'(MAX_COLS);

    logic [8:0]         w_nrows;
    logic [8:0]         w_ncols;
    logic               w_is_nbr;
    logic               w_shift_on;
    logic [4:0]         w_k;
    logic [3:0]         w_entry;
    logic signed [10:0] w_dr;
    logic signed [10:0] w_dc;
    logic signed [10:0] w_nr_s;
    logic signed [10:0] w_nc_s;
    logic signed [10:0] w_tr0;
    logic signed [10:0] w_tc0;
    logic signed [10:0] w_tr1;
    logic signed [10:0] w_tc1;
    logic [18:0]        w_lin;

    // The grid in use never exceeds the storage size.
    assign w_nrows = (13'(i_cfg.grid_rows) > LIM_ROWS) ? LIM_ROWS[8:0] : i_cfg.grid_rows;
    assign w_ncols = (13'(i_cfg.grid_columns) > LIM_COLS) ? LIM_COLS[8:0]
                                                           : i_cfg.grid_columns;

    assign w_is_nbr   = (i_req_type == acmdc_pkg::REQ_ADD_NEIGHBOR);
    assign w_shift_on = ((i_cfg.neighborhood_kind == acmdc_pkg::NBR_HEX_COL) && i_col[0]) ||
                        ((i_cfg.neighborhood_kind == acmdc_pkg::NBR_HEX_ROW) && i_row[0]);
    assign w_k        = {1'b0, i_neighbor_index} +
                        (w_shift_on ? {1'b0, i_cfg.hex_index_shift} : 5'd0);
    assign w_entry    = i_cfg.neighbor_offsets[{w_k[3:0], 2'b00} +: 4];

    assign w_dr   = {{9{w_entry[1]}}, w_entry[1:0]};
    assign w_dc   = {{9{w_entry[3]}}, w_entry[3:2]};
    assign w_nr_s = {2'b00, w_nrows};
    assign w_nc_s = {2'b00, w_ncols};
    assign w_tr0  = $signed({3'b000, i_row}) + (w_is_nbr ? w_dr : 11'sd0);
    assign w_tc0  = $signed({3'b000, i_col}) + (w_is_nbr ? w_dc : 11'sd0);

    // A single wrap step, and only for neighbour requests.
    always_comb begin
        w_tr1 = w_tr0;
        w_tc1 = w_tc0;
        if (w_is_nbr && i_cfg.toroidal_mode) begin
            if (w_tr0 < 0) begin
                w_tr1 = w_tr0 + w_nr_s;
            end else if (w_tr0 >= w_nr_s) begin
                w_tr1 = w_tr0 - w_nr_s;
            end
            if (w_tc0 < 0) begin
                w_tc1 = w_tc0 + w_nc_s;
            end else if (w_tc0 >= w_nc_s) begin
                w_tc1 = w_tc0 - w_nc_s;
            end
        end
    end

    assign o_target.oor = (w_is_nbr && w_k[4]) ||
                          (w_tr1 < 0) || (w_tr1 >= w_nr_s) ||
                          (w_tc1 < 0) || (w_tc1 >= w_nc_s);
    assign o_target.row = w_tr1[8:0];
    assign o_target.col = w_tc1[8:0];

    // In-grid targets always give an index below the cell count.
    assign w_lin = 19'(w_tr1[8:0]) * 19'(w_ncols) + 19'(w_tc1[8:0]);
    assign o_lin = LIN_W'(w_lin);

endmodule
